// ===== rtl/kss_pkg.sv =====
`default_nettype none
package kss_pkg;

    // Internal word: signed Q.32 in 64 bits.
    localparam int unsigned IW = 64;

    localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_I      = PI_Q60 >> 28;
    localparam logic [63:0] HALF_PI_I = PI_Q60 >> 29;
    localparam logic [63:0] TWO_PI_I  = PI_Q60 >> 27;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic signed [63:0] LIM = 64'sh0004_0000_0000_0000;
    localparam logic [63:0] LIM2 = 64'h0008_0000_0000_0000;

    // Configuration register indexes.
    localparam logic [1:0] REG_TOL_X    = 2'd0;
    localparam logic [1:0] REG_TOL_F    = 2'd1;
    localparam logic [1:0] REG_MAX_ITER = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SIN_L,
        OP_SIN_R,
        OP_SIN_X,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_DIV_RES
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic early_width;
        logic fl_small;
        logic fr_small;
        logic df_zero;
        logic conv_stop;
    } t_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHK_W,
        ST_SIN_L,
        ST_CHK_L,
        ST_SIN_R,
        ST_CHK_R,
        ST_ZCHK,
        ST_DIV,
        ST_SIN_X,
        ST_UPD,
        ST_RES,
        ST_TEST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        FIN_MID,
        FIN_XL,
        FIN_XR,
        FIN_LOOP
    } t_fin;

    // Arctangent table, Q.32, rounded from a Q.62 series.
    function automatic logic signed [63:0] atan_q32(input int i);
        logic signed [63:0] sum;
        logic [63:0] term;
        int p;
        sum = 64'sd0;
        if (i == 0) begin
            atan_q32 = signed'((PI_Q60 + (64'd1 << 29)) >> 30);
        end else begin
            for (int k = 0; k < 32; k++) begin
                p = i * (2 * k + 1);
                if (p <= 62) begin
                    term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
                    sum = (k % 2 == 1) ? sum - signed'(term) : sum + signed'(term);
                end
            end
            atan_q32 = (sum + 64'sd536870912) >>> 30;
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kss_muldiv.sv =====
`default_nettype none
// floor(a*b/d) of 64-bit operands, saturated to all ones on overflow or a zero divisor.
// The product is built from four 32x32 partials, then 64 restoring division steps.
module kss_muldiv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    input  wire logic [63:0] i_d,
    output logic             o_done,
    output logic [63:0]      o_q
);
    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md;

    t_md          r_st;
    logic [1:0]   r_pp;
    logic [6:0]   r_cnt;
    logic [63:0]  r_a, r_b, r_d, r_q;
    logic [127:0] r_p;
    logic [63:0]  r_hi, r_lo;
    logic         r_done;
    logic [63:0]  w_part;
    logic [31:0]  w_x, w_y;
    logic [64:0]  w_sh;

    // One partial product per cycle.
    always_comb begin
        w_x = r_pp[0] ? r_a[63:32] : r_a[31:0];
        w_y = r_pp[1] ? r_b[63:32] : r_b[31:0];
        w_part = 64'(w_x) * 64'(w_y);
        w_sh = {r_hi, r_lo[63]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= MD_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                MD_IDLE: begin
                    if (i_start) begin
                        r_a <= i_a; r_b <= i_b; r_d <= i_d;
                        r_p <= '0; r_pp <= 2'd0; r_st <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_p <= r_p + (128'(w_part) << (32 * (32'(r_pp[0]) + 32'(r_pp[1]))));
                    r_pp <= r_pp + 2'd1;
                    if (r_pp == 2'd3) begin
                        r_st <= MD_DIV;
                        r_cnt <= 7'd0;
                    end
                end
                MD_DIV: begin
                    if (r_cnt == 7'd0) begin
                        if (r_d == 64'd0 || r_p[127:64] >= r_d) begin
                            r_q <= '1;
                            r_st <= MD_IDLE;
                            r_done <= 1'b1;
                        end else begin
                            r_hi <= r_p[127:64]; r_lo <= r_p[63:0];
                            r_q <= '0; r_cnt <= 7'd1;
                        end
                    end else begin
                        if (w_sh >= 65'(r_d)) begin
                            r_hi <= 64'(w_sh - 65'(r_d));
                            r_q <= {r_q[62:0], 1'b1};
                        end else begin
                            r_hi <= w_sh[63:0];
                            r_q <= {r_q[62:0], 1'b0};
                        end
                        r_lo <= {r_lo[62:0], 1'b0};
                        if (r_cnt == 7'd64) begin
                            r_st <= MD_IDLE;
                            r_done <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                default: r_st <= MD_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== rtl/kss_kepler_f.sv =====
`default_nettype none
// Residual x - e*sin(x) - m: angle reduction, CORDIC rotation, then the e product.
module kss_kepler_f #(
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_x,
    input  wire logic signed [63:0] i_m,
    input  wire logic [31:0]        i_e,
    output logic                    o_done,
    output logic signed [63:0]      o_f
);
    import kss_pkg::*;

    localparam int SW = (CORDIC_STEPS > 63) ? 6 : $clog2(CORDIC_STEPS + 1);

    typedef enum logic [2:0] {KF_IDLE, KF_RED, KF_FOLD, KF_ROT, KF_MUL, KF_OUT} t_kf;

    t_kf                r_st;
    logic signed [63:0] r_x, r_m, r_cx, r_cy, r_cz;
    logic [63:0]        r_a, r_es;
    logic [31:0]        r_e;
    logic               r_neg, r_done;
    logic [SW-1:0]      r_i;
    logic [6:0]         r_rb;
    logic signed [63:0] w_atan;
    logic [63:0]        w_sy;
    logic [63:0]        w_tr;

    // Arctangent lookup and |sin| for the final product.
    always_comb begin
        w_atan = 64'sd0;
        for (int k = 0; k < 64; k++) begin
            if (32'(r_i) == k) w_atan = atan_q32(k);
        end
        w_sy = mag64(r_cy);
        w_tr = TWO_PI_I << r_rb[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= KF_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                KF_IDLE: begin
                    if (i_start) begin
                        r_x <= i_x; r_m <= i_m; r_e <= i_e;
                        r_neg <= i_x[63];
                        r_a <= mag64(i_x);
                        r_rb <= 7'd16;
                        r_st <= KF_RED;
                    end
                end
                // Modulo 2*pi by shift-and-subtract; |x| stays within 2^50, so the
                // quotient fits in sixteen bits.
                KF_RED: begin
                    if (r_a >= w_tr && (w_tr >> r_rb[5:0]) == TWO_PI_I) r_a <= r_a - w_tr;
                    if (r_rb == 7'd0) r_st <= KF_FOLD;
                    else r_rb <= r_rb - 7'd1;
                end
                KF_FOLD: begin
                    if (r_a >= PI_I) begin
                        r_neg <= ~r_neg;
                        r_cz <= signed'(((r_a - PI_I) > HALF_PI_I) ?
                            (PI_I - (r_a - PI_I)) : (r_a - PI_I));
                    end else begin
                        r_cz <= signed'((r_a > HALF_PI_I) ? (PI_I - r_a) : r_a);
                    end
                    r_cx <= CORDIC_GAIN;
                    r_cy <= 64'sd0;
                    r_i <= '0;
                    r_st <= KF_ROT;
                end
                // One rotation step per cycle.
                KF_ROT: begin
                    if (32'(r_i) >= CORDIC_STEPS || 32'(r_i) >= 64) begin
                        r_st <= KF_MUL;
                    end else begin
                        if (!r_cz[63]) begin
                            r_cx <= r_cx - (r_cy >>> r_i);
                            r_cy <= r_cy + (r_cx >>> r_i);
                            r_cz <= r_cz - w_atan;
                        end else begin
                            r_cx <= r_cx + (r_cy >>> r_i);
                            r_cy <= r_cy - (r_cx >>> r_i);
                            r_cz <= r_cz + w_atan;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                // |sin| is below 2^31, so one 32x32 product.
                KF_MUL: begin
                    r_es <= (64'(r_e) * 64'(w_sy[31:0])) >> 30;
                    r_st <= KF_OUT;
                end
                KF_OUT: begin
                    if ((r_cy != 64'sd0) && (r_cy[63] ^ r_neg))
                        o_f <= r_x + signed'(r_es) - r_m;
                    else if (r_cy != 64'sd0)
                        o_f <= r_x - signed'(r_es) - r_m;
                    else
                        o_f <= r_x - r_m;
                    r_done <= 1'b1;
                    r_st <= KF_IDLE;
                end
                default: r_st <= KF_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/kss_datapath.sv =====
`default_nettype none
// Secant datapath: iterate pair, residuals, step and residual divide, output formatting.
module kss_datapath #(
    parameter int FRAC_BITS    = 28,
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire kss_pkg::t_cmd        i_cmd,
    input  wire kss_pkg::t_fin        i_fin,
    input  wire logic                 i_zero_stop,
    input  wire logic [31:0]          i_eccentricity,
    input  wire logic signed [31:0]   i_mean_anomaly,
    input  wire logic [31:0]          i_tol_x,
    input  wire logic [31:0]          i_tol_f,
    input  wire logic [7:0]           i_max_iter,
    output kss_pkg::t_stat            o_stat,
    output logic signed [31:0]        o_ecc_anomaly,
    output logic [7:0]                o_iterations,
    output logic [31:0]               o_step_error,
    output logic [31:0]               o_residual_error,
    output logic                      o_status
);
    import kss_pkg::*;

    // Destination tags for results of the shared units.
    localparam logic [1:0] TAG_LO  = 2'd0;
    localparam logic [1:0] TAG_HI  = 2'd1;
    localparam logic [1:0] TAG_NEW = 2'd2;

    logic signed [63:0] r_m, r_xl, r_xr, r_fl, r_fr, r_x, r_fx;
    logic [31:0]        r_e;
    logic [63:0]        r_tx, r_tf, r_dx, r_df;
    logic [7:0]         r_cnt;
    logic [1:0]         r_tag;
    logic               r_busy;
    logic               w_f_start, w_f_done, w_d_start, w_d_done;
    logic signed [63:0] w_f_in, w_f;
    logic [63:0]        w_da, w_db, w_dd, w_q, w_qs;
    logic signed [63:0] w_dxs, w_dfs, w_xn, w_out_v;
    logic               w_neg;

    // Field to internal Q.32.
    function automatic logic signed [63:0] to_int_s(input logic signed [31:0] v);
        if (FRAC_BITS <= 32) to_int_s = 64'(v) <<< (32 - FRAC_BITS);
        else to_int_s = 64'(v) >>> (FRAC_BITS - 32);
    endfunction
    function automatic logic [63:0] to_int_u(input logic [31:0] v);
        if (FRAC_BITS <= 32) to_int_u = 64'(v) << (32 - FRAC_BITS);
        else to_int_u = 64'(v) >> (FRAC_BITS - 32);
    endfunction
    // Internal Q.32 to field, saturating.
    function automatic logic [31:0] from_int_s(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (FRAC_BITS <= 32) r = v >>> (32 - FRAC_BITS);
        else if (v > (64'sh7FFFFFFF >>> (FRAC_BITS - 32))) r = 64'sh7FFFFFFF;
        else if (v < -(64'sd1 <<< (63 - FRAC_BITS))) r = -64'sh80000000;
        else r = v <<< (FRAC_BITS - 32);
        if (r > 64'sh7FFFFFFF) from_int_s = 32'h7FFFFFFF;
        else if (r < -64'sh80000000) from_int_s = 32'h80000000;
        else from_int_s = r[31:0];
    endfunction
    function automatic logic [31:0] from_int_u(input logic [63:0] v);
        logic [63:0] r;
        if (FRAC_BITS <= 32) r = v >> (32 - FRAC_BITS);
        else r = (v > (64'hFFFFFFFF >> (FRAC_BITS - 32))) ? 64'hFFFFFFFF :
                 (v << (FRAC_BITS - 32));
        from_int_u = (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
    endfunction

    assign w_f_start = (i_cmd.op == OP_SIN_L) || (i_cmd.op == OP_SIN_R) ||
                       (i_cmd.op == OP_SIN_X);
    assign w_d_start = (i_cmd.op == OP_DIV_STEP) || (i_cmd.op == OP_DIV_RES);

    always_comb begin
        w_f_in = (i_cmd.op == OP_SIN_L) ? r_xl : ((i_cmd.op == OP_SIN_R) ? r_xr : r_x);
        w_dxs = r_xr - r_xl;
        w_dfs = r_fr - r_fl;
        if (i_cmd.op == OP_DIV_RES) begin
            w_da = mag64(r_fr);
            w_db = 64'(r_e);
            w_dd = (64'd1 << 32) - 64'(r_e);
        end else begin
            w_da = mag64(r_fr);
            w_db = mag64(w_dxs);
            w_dd = mag64(w_dfs);
        end
        w_qs = (w_q > LIM2) ? LIM2 : w_q;
        w_neg = (r_fr[63] != w_dxs[63]) != w_dfs[63];
        w_xn = w_neg ? r_xr + signed'(w_qs) : r_xr - signed'(w_qs);
        if (w_xn > LIM) w_xn = LIM;
        if (w_xn < -LIM) w_xn = -LIM;
        unique case (i_fin)
            FIN_MID: w_out_v = (r_xl + r_xr) >>> 1;
            FIN_XL:  w_out_v = r_xl;
            FIN_XR:  w_out_v = r_xr;
            default: w_out_v = r_xr;
        endcase
    end

    kss_kepler_f #(.CORDIC_STEPS(CORDIC_STEPS)) u_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_f_start),
        .i_x(w_f_in), .i_m(r_m), .i_e(r_e), .o_done(w_f_done), .o_f(w_f)
    );

    kss_muldiv u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_d_start),
        .i_a(w_da), .i_b(w_db), .i_d(w_dd), .o_done(w_d_done), .o_q(w_q)
    );

    // Busy flag covers the time a shared unit is running.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_f_start || w_d_start) begin
            r_busy <= 1'b1;
        end else if (w_f_done || w_d_done) begin
            r_busy <= 1'b0;
        end
    end

    // Operand, iterate and result registers. Results from the shared units land
    // by the tag set when the operation was issued.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_e <= i_eccentricity;
                r_m <= to_int_s(i_mean_anomaly);
                r_xl <= to_int_s(i_mean_anomaly);
                r_xr <= to_int_s(i_mean_anomaly) + signed'(64'(i_eccentricity));
                r_tx <= to_int_u(i_tol_x);
                r_tf <= to_int_u(i_tol_f);
                r_cnt <= 8'd0;
                r_df <= 64'd0;
                r_dx <= 64'(i_eccentricity);
            end
            OP_SIN_L:    r_tag <= TAG_LO;
            OP_SIN_R:    r_tag <= TAG_HI;
            OP_SIN_X:    r_tag <= TAG_NEW;
            OP_DIV_STEP: r_tag <= TAG_LO;
            OP_DIV_RES:  r_tag <= TAG_HI;
            OP_UPDATE: begin
                r_xl <= r_xr; r_fl <= r_fr;
                r_xr <= r_x; r_fr <= r_fx;
                r_cnt <= r_cnt + 8'd1;
                r_dx <= mag64(r_x - r_xr);
            end
            default: ;
        endcase
        if (w_f_done) begin
            unique case (r_tag)
                TAG_LO:  r_fl <= w_f;
                TAG_HI:  r_fr <= w_f;
                default: r_fx <= w_f;
            endcase
        end
        if (w_d_done) begin
            if (r_tag == TAG_LO) r_x <= w_xn;
            else r_df <= w_q;
        end
    end

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.early_width = 64'(r_e) < r_tx;
        o_stat.fl_small = mag64(r_fl) < r_tf;
        o_stat.fr_small = mag64(r_fr) < r_tf;
        o_stat.df_zero = (w_dfs == 64'sd0);
        o_stat.conv_stop = !((r_dx > r_tx) && (r_df > r_tf) &&
                             (r_cnt < i_max_iter));
        o_ecc_anomaly = signed'(from_int_s(w_out_v));
        if (i_fin == FIN_LOOP) begin
            o_iterations = r_cnt;
            o_step_error = from_int_u(r_dx);
            o_residual_error = from_int_u(r_df);
            o_status = i_zero_stop;
        end else begin
            o_iterations = 8'd1;
            o_step_error = 32'd0;
            o_residual_error = 32'd0;
            o_status = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/kss_ctrl.sv =====
`default_nettype none
// Solve sequencer: early-exit checks, then secant rounds until a stop condition.
module kss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire kss_pkg::t_stat  i_stat,
    output kss_pkg::t_cmd        o_cmd,
    output kss_pkg::t_fin        o_fin,
    output logic                 o_zero_stop
);
    import kss_pkg::*;

    t_state r_state, n_state;
    t_fin   r_fin, n_fin;
    logic   r_zero, n_zero;
    logic   r_issued, n_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin <= FIN_LOOP;
            r_zero <= 1'b0;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin <= n_fin;
            r_zero <= n_zero;
            r_issued <= n_issued;
        end
    end

    // Long operations: issue once, then wait for the busy flag to drop.
    always_comb begin
        n_state = r_state;
        n_fin = r_fin;
        n_zero = r_zero;
        n_issued = 1'b0;
        o_cmd.op = OP_NONE;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_zero = 1'b0;
                    n_state = ST_CHK_W;
                end
            end
            ST_LOAD: n_state = ST_CHK_W;
            ST_CHK_W: begin
                if (i_stat.early_width) begin
                    n_fin = FIN_MID; n_state = ST_DONE;
                end else begin
                    n_state = ST_SIN_L;
                end
            end
            ST_SIN_L: begin
                if (!r_issued) begin
                    o_cmd.op = OP_SIN_L; n_issued = 1'b1;
                end else if (!i_stat.busy) begin
                    n_state = ST_CHK_L;
                end else begin
                    n_issued = 1'b1;
                end
            end
            ST_CHK_L: begin
                if (i_stat.fl_small) begin
                    n_fin = FIN_XL; n_state = ST_DONE;
                end else begin
                    n_state = ST_SIN_R;
                end
            end
            ST_SIN_R: begin
                if (!r_issued) begin
                    o_cmd.op = OP_SIN_R; n_issued = 1'b1;
                end else if (!i_stat.busy) begin
                    n_state = ST_CHK_R;
                end else begin
                    n_issued = 1'b1;
                end
            end
            ST_CHK_R: begin
                if (i_stat.fr_small) begin
                    n_fin = FIN_XR; n_state = ST_DONE;
                end else begin
                    n_fin = FIN_LOOP; n_state = ST_ZCHK;
                end
            end
            ST_ZCHK: begin
                if (i_stat.df_zero) begin
                    n_zero = 1'b1; n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!r_issued) begin
                    o_cmd.op = OP_DIV_STEP; n_issued = 1'b1;
                end else if (!i_stat.busy) begin
                    n_state = ST_SIN_X;
                end else begin
                    n_issued = 1'b1;
                end
            end
            ST_SIN_X: begin
                if (!r_issued) begin
                    o_cmd.op = OP_SIN_X; n_issued = 1'b1;
                end else if (!i_stat.busy) begin
                    n_state = ST_UPD;
                end else begin
                    n_issued = 1'b1;
                end
            end
            ST_UPD: begin
                o_cmd.op = OP_UPDATE;
                n_state = ST_RES;
            end
            ST_RES: begin
                if (!r_issued) begin
                    o_cmd.op = OP_DIV_RES; n_issued = 1'b1;
                end else if (!i_stat.busy) begin
                    n_state = ST_TEST;
                end else begin
                    n_issued = 1'b1;
                end
            end
            ST_TEST: n_state = i_stat.conv_stop ? ST_DONE : ST_ZCHK;
            ST_DONE: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_fin = r_fin;
    assign o_zero_stop = r_zero;
endmodule
`default_nettype wire

// ===== rtl/kepler_secant_solver.sv =====
`default_nettype none
// Solves Kepler's equation E - e*sin(E) = M by secant iteration, one request at a
// time. A residual evaluation is an angle reduction, a CORDIC rotation of one step
// per cycle, and the e product. Each secant round needs one evaluation and two
// 64-bit multiply-divides, and the number of rounds is bounded by max_iter.
// Results are held until taken. The user must write configuration only while
// idle (the block itself does not enforce this); it then applies to the next
// request.
module kepler_secant_solver #(
    parameter int FRAC_BITS    = 28,
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [31:0]        i_eccentricity,
    input  wire logic signed [31:0] i_mean_anomaly,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_ecc_anomaly,
    output logic [7:0]              o_iterations,
    output logic [31:0]             o_step_error,
    output logic [31:0]             o_residual_error,
    output logic                    o_status,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import kss_pkg::*;

    logic [31:0] r_tol_x, r_tol_f;
    logic [7:0]  r_max_iter;
    t_cmd        w_cmd;
    t_stat       w_stat;
    t_fin        w_fin;
    logic        w_zero;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_x <= 32'd4;
            r_tol_f <= 32'd4;
            r_max_iter <= 8'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TOL_X:    r_tol_x <= i_cfg_data;
                REG_TOL_F:    r_tol_f <= i_cfg_data;
                REG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    kss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_fin(w_fin), .o_zero_stop(w_zero)
    );

    kss_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_fin(w_fin),
        .i_zero_stop(w_zero), .i_eccentricity(i_eccentricity),
        .i_mean_anomaly(i_mean_anomaly), .i_tol_x(r_tol_x), .i_tol_f(r_tol_f),
        .i_max_iter(r_max_iter), .o_stat(w_stat), .o_ecc_anomaly(o_ecc_anomaly),
        .o_iterations(o_iterations), .o_step_error(o_step_error),
        .o_residual_error(o_residual_error), .o_status(o_status)
    );
endmodule
`default_nettype wire
